FILE: hdl/tlex_pkg.sv
// Shared definitions for the token lexer: field widths, token kind codes,
// input opcodes, keyword spellings and the token and result records.
// No dependencies; every other file imports this package.
`default_nettype none

package tlex_pkg;

  localparam int LINE_BITS     = 16;
  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int KIND_BITS     = 5;
  localparam int CHAR_BITS     = 8;
  localparam int OP_BITS       = 2;
  localparam int KW_BITS       = 40;

  // Output beat payload, packed from bit 0 up and padded to whole bytes.
  localparam int TOKEN_BITS     = KIND_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS;
  localparam int OUT_DATA_BITS  = ((TOKEN_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - TOKEN_BITS;

  localparam logic [LINE_BITS-1:0] FIRST_LINE_RESET = LINE_BITS'(1);

  typedef enum logic [OP_BITS-1:0] {
    OP_CHAR  = 2'd0,
    OP_END   = 2'd1,
    OP_RDERR = 2'd2
  } opcode_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_IF, K_THEN, K_PRINT, K_TRUE, K_FALSE, K_IDENT, K_ICONST, K_SCONST,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_ASSIGN, K_EQ, K_NEQ, K_LT, K_LEQ,
    K_GT, K_GEQ, K_AND, K_OR, K_SC, K_LPAREN, K_RPAREN, K_ERR, K_DONE
  } kind_t;

  // Keyword spellings, first letter in the lowest byte.
  localparam logic [KW_BITS-1:0] KW_IF    = 40'h00_00_00_66_69;
  localparam logic [KW_BITS-1:0] KW_THEN  = 40'h00_6e_65_68_74;
  localparam logic [KW_BITS-1:0] KW_PRINT = 40'h74_6e_69_72_70;
  localparam logic [KW_BITS-1:0] KW_TRUE  = 40'h00_65_75_72_74;
  localparam logic [KW_BITS-1:0] KW_FALSE = 40'h65_73_6c_61_66;

  typedef struct packed {
    logic [LENGTH_BITS-1:0]   length;
    logic [POSITION_BITS-1:0] start;
    logic [LINE_BITS-1:0]     line;
    kind_t                    kind;
    logic                     last;
  } token_t;

  // Tokens produced by one accepted input beat (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    token_t     tok1;
    token_t     tok0;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: hdl/tlex_scan.sv
// Scanner core: state registers of the lexer and the single-pass next-state
// and token logic for one input beat. Depends on tlex_pkg.
`default_nettype none

module tlex_scan
  import tlex_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [OP_BITS-1:0]   opcode,
  input  wire logic [CHAR_BITS-1:0] ch,
  input  wire logic [LINE_BITS-1:0] line_load,
  output scan_res_t                 res
);

  typedef enum logic [3:0] {
    S_BEGIN, S_ID, S_STR, S_MINUS, S_EQ, S_LT, S_GT, S_AND, S_OR, S_INT, S_CMT
  } scan_state_t;

  scan_state_t              state, state_next;
  logic [LINE_BITS-1:0]     line_count, line_count_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] pend_start, pend_start_next;
  logic [LENGTH_BITS-1:0]   pend_len, pend_len_next;
  logic [KW_BITS-1:0]       kw_letters, kw_letters_next;

  token_t     toks [2];
  logic [1:0] n_emit;
  logic       do_idle;
  kind_t      pair_kind, pair_hit, idle_kind;
  logic       is_nl;

  function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c inside {8'h20, [8'h09:8'h0d]});
  endfunction

  function automatic kind_t ident_kind(input logic [LENGTH_BITS-1:0] len,
                                       input logic [KW_BITS-1:0] w);
    kind_t k;
    k = K_IDENT;
    if (len == LENGTH_BITS'(2) && w == KW_IF) k = K_IF;
    else if (len == LENGTH_BITS'(4) && w == KW_THEN) k = K_THEN;
    else if (len == LENGTH_BITS'(5) && w == KW_PRINT) k = K_PRINT;
    else if (len == LENGTH_BITS'(4) && w == KW_TRUE) k = K_TRUE;
    else if (len == LENGTH_BITS'(5) && w == KW_FALSE) k = K_FALSE;
    return k;
  endfunction

  always_comb begin
    state_next      = state;
    line_count_next = line_count;
    position_next   = position;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    kw_letters_next = kw_letters;
    toks[0]         = '0;
    toks[1]         = '0;
    n_emit          = 2'd0;
    do_idle         = 1'b0;
    pair_kind       = K_ASSIGN;
    pair_hit        = K_EQ;
    idle_kind       = K_ERR;
    is_nl           = (ch == 8'h0a);

    if (accept) begin
      if (opcode == OP_CHAR) begin
        case (state)
          S_ID: begin
            if (is_alpha(ch) || is_digit(ch)) begin
              if (pend_len < LENGTH_BITS'(5)) begin
                kw_letters_next[{pend_len[2:0], 3'b000} +: 8] = ch;
              end
              if (pend_len != '1) pend_len_next = pend_len + 1'b1;
            end else begin
              toks[n_emit[0]] = '{length: pend_len, start: pend_start, line: line_count_next,
                                  kind: ident_kind(pend_len, kw_letters), last: 1'b0};
              n_emit  = n_emit + 1'b1;
              do_idle = 1'b1;
            end
          end
          S_STR: begin
            if (pend_len != '1) pend_len_next = pend_len + 1'b1;
            if (is_nl) begin
              if (line_count != '1) line_count_next = line_count + 1'b1;
              state_next = S_BEGIN;
              toks[n_emit[0]] = '{length: pend_len_next, start: pend_start,
                                  line: line_count_next, kind: K_ERR, last: 1'b0};
              n_emit = n_emit + 1'b1;
            end else if (ch == 8'h22) begin
              // Both quotes are left out of the string lexeme.
              state_next = S_BEGIN;
              toks[n_emit[0]] = '{length: pend_len_next - LENGTH_BITS'(2),
                                  start: pend_start + 1'b1,
                                  line: line_count_next, kind: K_SCONST, last: 1'b0};
              n_emit = n_emit + 1'b1;
            end
          end
          S_MINUS: begin
            if (is_digit(ch)) begin
              if (pend_len != '1) pend_len_next = pend_len + 1'b1;
              state_next = S_INT;
            end else begin
              toks[n_emit[0]] = '{length: pend_len, start: pend_start, line: line_count_next,
                                  kind: K_MINUS, last: 1'b0};
              n_emit  = n_emit + 1'b1;
              do_idle = 1'b1;
            end
          end
          S_INT: begin
            if (is_digit(ch)) begin
              if (pend_len != '1) pend_len_next = pend_len + 1'b1;
            end else if (is_alpha(ch)) begin
              // A letter glued to a number makes the whole lexeme an error.
              if (pend_len != '1) pend_len_next = pend_len + 1'b1;
              state_next = S_BEGIN;
              toks[n_emit[0]] = '{length: pend_len_next, start: pend_start,
                                  line: line_count_next, kind: K_ERR, last: 1'b0};
              n_emit = n_emit + 1'b1;
            end else begin
              toks[n_emit[0]] = '{length: pend_len, start: pend_start, line: line_count_next,
                                  kind: K_ICONST, last: 1'b0};
              n_emit  = n_emit + 1'b1;
              do_idle = 1'b1;
            end
          end
          S_AND, S_OR: begin
            // The second byte is consumed whether or not it completes the pair.
            if (is_nl && line_count != '1) line_count_next = line_count + 1'b1;
            state_next = S_BEGIN;
            if ((state == S_AND && ch == 8'h26) || (state == S_OR && ch == 8'h7c)) begin
              toks[n_emit[0]] = '{length: LENGTH_BITS'(2), start: pend_start,
                                  line: line_count_next,
                                  kind: (state == S_AND) ? K_AND : K_OR, last: 1'b0};
            end else begin
              toks[n_emit[0]] = '{length: LENGTH_BITS'(1), start: pend_start,
                                  line: line_count_next, kind: K_ERR, last: 1'b0};
            end
            n_emit = n_emit + 1'b1;
          end
          S_CMT: begin
            if (is_nl) begin
              if (line_count != '1) line_count_next = line_count + 1'b1;
              state_next = S_BEGIN;
            end
          end
          S_EQ, S_LT, S_GT: begin
            if (state == S_LT) begin
              pair_kind = K_LT;
              pair_hit  = K_LEQ;
            end else if (state == S_GT) begin
              pair_kind = K_GT;
              pair_hit  = K_GEQ;
            end
            if (ch == 8'h3d) begin
              state_next = S_BEGIN;
              toks[n_emit[0]] = '{length: LENGTH_BITS'(2), start: pend_start,
                                  line: line_count_next, kind: pair_hit, last: 1'b0};
              n_emit = n_emit + 1'b1;
            end else begin
              toks[n_emit[0]] = '{length: pend_len, start: pend_start, line: line_count_next,
                                  kind: pair_kind, last: 1'b0};
              n_emit  = n_emit + 1'b1;
              do_idle = 1'b1;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        // Scan from the idle state: a fresh byte, or one a token just rejected.
        if (do_idle) begin
          if (is_nl && line_count_next != '1) line_count_next = line_count_next + 1'b1;
          state_next = S_BEGIN;
          if (!is_space(ch)) begin
            pend_start_next = position;
            pend_len_next   = LENGTH_BITS'(1);
            kw_letters_next = '0;
            if (is_alpha(ch)) begin
              kw_letters_next = KW_BITS'(ch);
              state_next      = S_ID;
            end else if (is_digit(ch)) begin
              state_next = S_INT;
            end else begin
              case (ch)
                8'h22:   state_next = S_STR;
                8'h2d:   state_next = S_MINUS;
                8'h3d:   state_next = S_EQ;
                8'h3e:   state_next = S_GT;
                8'h3c:   state_next = S_LT;
                8'h26:   state_next = S_AND;
                8'h7c:   state_next = S_OR;
                8'h23:   state_next = S_CMT;
                8'h2b:   idle_kind  = K_PLUS;
                8'h2a:   idle_kind  = K_STAR;
                8'h2f:   idle_kind  = K_SLASH;
                8'h28:   idle_kind  = K_LPAREN;
                8'h29:   idle_kind  = K_RPAREN;
                8'h3b:   idle_kind  = K_SC;
                default: idle_kind  = K_ERR;
              endcase
              if (state_next == S_BEGIN) begin
                toks[n_emit[0]] = '{length: LENGTH_BITS'(1), start: position,
                                    line: line_count_next, kind: idle_kind, last: 1'b0};
                n_emit = n_emit + 1'b1;
              end
            end
          end
        end
        position_next = position + 1'b1;
      end else begin
        // End of input or read error drops the pending lexeme.
        state_next      = S_BEGIN;
        pend_len_next   = '0;
        kw_letters_next = '0;
        toks[0] = '{length: '0, start: position, line: line_count,
                    kind: (opcode == OP_END) ? K_DONE : K_ERR, last: 1'b0};
        n_emit = 2'd1;
      end
    end

    if (n_emit == 2'd1) toks[0].last = 1'b1;
    if (n_emit == 2'd2) toks[1].last = 1'b1;
  end

  assign res.count = n_emit;
  assign res.tok0  = toks[0];
  assign res.tok1  = toks[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_BEGIN;
      line_count <= line_load;
      position   <= '0;
      pend_start <= '0;
      pend_len   <= '0;
      kw_letters <= '0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      position   <= position_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      kw_letters <= kw_letters_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlex_fifo.sv
// Four-entry token queue that takes up to two tokens per cycle and hands out
// one per cycle while the reader is ready. Depends on tlex_pkg.
`default_nettype none

module tlex_fifo
  import tlex_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire scan_res_t wr,
  output logic           has_room,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output token_t         rd_tok
);

  token_t     slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;
  logic       pop;

  assign pop       = rd_valid && rd_ready;
  assign rd_valid  = (fill != 3'd0);
  assign rd_tok    = slots[rd_ptr];
  // Room for the worst case of two tokens from one beat.
  assign has_room  = (fill <= 3'd2);
  assign fill_next = fill + {1'b0, wr.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) slots[wr_ptr] <= wr.tok0;
    if (wr.count == 2'd2) slots[wr_ptr + 2'd1] <= wr.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/token_lexer_fsm_unit.sv
// Top level of the byte-serial token lexer: stream ports, the first-line
// register, the scanner core and the output token queue.
// Depends on tlex_pkg, tlex_scan and tlex_fifo.
//
//   channel   | ports                         | payload (lowest bit first)
//   ----------+-------------------------------+----------------------------------------
//   input     | s_tvalid s_tready s_tdata     | tdata: character[7:0]
//             | s_tuser                       | tuser: opcode[1:0]
//   output    | m_tvalid m_tready m_tdata     | tdata: token_kind[4:0] line_number[20:5]
//             | m_tlast                       |   text_start[52:21] text_length[68:53]
//             |                               | tlast: last_of_run
//   config    | cfg_we cfg_data               | first_line_number[15:0]
//
// Every input beat is handled in the cycle it is accepted: the scanner state
// is updated at that edge and its zero, one or two tokens are written to a
// four-entry queue, so a new beat can be accepted in every cycle in which
// the queue has room. The queue sends one token per cycle while m_tready is
// high; s_tready drops only while fewer than two slots are free, which
// happens when beats producing two tokens arrive back to back or the output
// side stalls. Reset (rst, synchronous) clears the queue, returns the
// scanner to its idle state at stream position zero and loads the line
// counter with the reset value of first_line_number.
`default_nettype none

module token_lexer_fsm_unit
  import tlex_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [CHAR_BITS-1:0]     s_tdata,   // character[7:0]
  input  wire logic [OP_BITS-1:0]       s_tuser,   // opcode[1:0]
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0]      m_tdata,   // kind, line, start, length, pad
  output logic                          m_tlast,   // last token of its input beat
  input  wire logic                     cfg_we,
  input  wire logic [LINE_BITS-1:0]     cfg_data
);

  logic [LINE_BITS-1:0] first_line, first_line_next;
  logic                 accept;
  scan_res_t            res;
  token_t               out_tok;

  // The line counter is loaded at reset with the value this register takes in
  // reset, so both start from FIRST_LINE_RESET together.
  always_comb begin
    first_line_next = first_line;
    if (rst) begin
      first_line_next = FIRST_LINE_RESET;
    end else if (cfg_we) begin
      first_line_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    first_line <= first_line_next;
  end

  assign accept = s_tvalid && s_tready;

  tlex_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (s_tuser),
    .ch        (s_tdata),
    .line_load (first_line_next),
    .res       (res)
  );

  tlex_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (res),
    .has_room (s_tready),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_tok   (out_tok)
  );

  // Output beat: fields packed from bit 0 upward, zero padding on top.
  assign m_tdata = {{OUT_PAD_BITS{1'b0}}, out_tok.length, out_tok.start,
                    out_tok.line, out_tok.kind};
  assign m_tlast = out_tok.last;

endmodule

`default_nettype wire
